/* hw/rtl/lvm_pkg.sv */
// ----------------------------------------------------------------------------
// lvm_pkg: shared types and constants of the look-at view matrix block
// Widths of the coordinate, unit vector and product formats, and the structs
// that carry jobs, normalizer status and result rows between the modules.
// ----------------------------------------------------------------------------
package lvm_pkg;

    localparam int COORD_W   = 32;              // Q16.16 coordinates
    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 30;              // unit vectors in Q2.30
    localparam int DIFF_W    = COORD_W + 1;     // target minus eye
    localparam int UNIT_W    = 32;
    localparam int ROW_W     = UNIT_W + 1;      // rounded true up may reach 2^31
    localparam int WIDE_W    = 64;              // cross products
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [UNIT_W-1:0]  t_unit;
    typedef logic signed [ROW_W-1:0]   t_row_v;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;

    typedef struct packed {
        t_coord eye_x;
        t_coord eye_y;
        t_coord eye_z;
        t_diff  d_x;
        t_diff  d_y;
        t_diff  d_z;
        t_coord up_x;
        t_coord up_y;
        t_coord up_z;
        logic   early_deg;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_stat;

    typedef struct packed {
        logic [1:0] row_index;
        t_coord     col_x;
        t_coord     col_y;
        t_coord     col_z;
        t_coord     offset;
        logic       degenerate;
        logic       final_row;
    } t_res;

endpackage

/* hw/rtl/lvm_front.sv */
// ----------------------------------------------------------------------------
// lvm_front: input side of the look-at block
// Takes setups, forms target minus eye, flags the trivially degenerate cases
// and holds jobs in a short queue for the back end.
// ----------------------------------------------------------------------------
module lvm_front import lvm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_coord   i_eye_x,
    input  t_coord   i_eye_y,
    input  t_coord   i_eye_z,
    input  t_coord   i_target_x,
    input  t_coord   i_target_y,
    input  t_coord   i_target_z,
    input  t_coord   i_up_x,
    input  t_coord   i_up_y,
    input  t_coord   i_up_z,
    output t_job_req o_req,
    input  logic     i_ready
);

    t_job              w_job;
    t_job              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_job.eye_x = i_eye_x;
        w_job.eye_y = i_eye_y;
        w_job.eye_z = i_eye_z;
        w_job.d_x   = $signed({i_target_x[COORD_W-1], i_target_x})
                    - $signed({i_eye_x[COORD_W-1], i_eye_x});
        w_job.d_y   = $signed({i_target_y[COORD_W-1], i_target_y})
                    - $signed({i_eye_y[COORD_W-1], i_eye_y});
        w_job.d_z   = $signed({i_target_z[COORD_W-1], i_target_z})
                    - $signed({i_eye_z[COORD_W-1], i_eye_z});
        w_job.up_x  = i_up_x;
        w_job.up_y  = i_up_y;
        w_job.up_z  = i_up_z;
        // Eye on target or a zero up vector can never give a basis.
        w_job.early_deg = ((w_job.d_x == '0) && (w_job.d_y == '0) && (w_job.d_z == '0))
                       || ((i_up_x == '0) && (i_up_y == '0) && (i_up_z == '0));
    end

    assign full        = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign w_push      = push && !full;
    assign o_req.valid = (r_cnt != '0);
    assign o_req.job   = r_q[r_rp];
    assign w_pop       = o_req.valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

/* hw/rtl/lvm_norm.sv */
// ----------------------------------------------------------------------------
// lvm_norm: iterative vector normalizer
// Scales a three-vector into [2^30, 2^31), sums the squares, takes a bitwise
// square root and divides each component by it, giving a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module lvm_norm import lvm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_wide      i_vec [3],
    output t_norm_stat o_stat,
    output t_unit      o_unit [3]
);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_MAX   = 7'b0000010,
        N_SCALE = 7'b0000100,
        N_SQ    = 7'b0001000,
        N_SQRT  = 7'b0010000,
        N_PREP  = 7'b0100000,
        N_DIV   = 7'b1000000
    } t_nstate;

    t_nstate            r_state;
    logic [WIDE_W-1:0]  r_m [3];
    logic [2:0]         r_neg;
    logic [WIDE_W-1:0]  r_mx;
    logic [WIDE_W-1:0]  w_mx;
    logic [61:0]        r_sq;
    logic [WIDE_W-1:0]  r_sum;
    logic [WIDE_W-1:0]  r_x;
    logic [34:0]        r_rem;
    logic [34:0]        w_rem;
    logic [34:0]        w_trial;
    logic [31:0]        r_root;
    logic [4:0]         r_cnt;
    logic [32:0]        r_drem [3];
    logic [30:0]        r_num [3];
    logic [30:0]        r_q [3];
    logic [61:0]        w_numer [3];
    logic [32:0]        w_dtry [3];
    logic               r_done;
    logic               r_zero;

    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) begin
            w_mx = r_m[1];
        end
        if (r_m[2] > w_mx) begin
            w_mx = r_m[2];
        end
        w_rem   = {r_rem[32:0], r_x[WIDE_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        for (int i = 0; i < 3; i++) begin
            w_numer[i] = {1'b0, r_m[i][30:0], 30'd0} + 62'(r_root >> 1);
            w_dtry[i]  = {r_drem[i][31:0], r_num[i][30]};
            o_unit[i]  = r_neg[i] ? -UNIT_W'(r_q[i]) : UNIT_W'(r_q[i]);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
            r_zero  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_vec[i][WIDE_W-1];
                            r_m[i]   <= i_vec[i][WIDE_W-1] ? WIDE_W'(-i_vec[i])
                                                           : WIDE_W'(i_vec[i]);
                        end
                        r_state <= N_MAX;
                    end
                end
                N_MAX: begin
                    if (w_mx == '0) begin
                        r_done  <= 1'b1;
                        r_zero  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_mx    <= w_mx;
                        r_state <= N_SCALE;
                    end
                end
                N_SCALE: begin
                    // Coarse steps of eight where they cannot overshoot the window.
                    priority if (r_mx[WIDE_W-1:39] != '0) begin
                        r_mx <= r_mx >> 8;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 8;
                    end else if (r_mx[WIDE_W-1:31] != '0) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (r_mx[30:22] == '0) begin
                        r_mx <= r_mx << 8;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 8;
                    end else if (!r_mx[30]) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_cnt < 5'd3) begin
                        r_sq <= r_m[r_cnt[1:0]][30:0] * r_m[r_cnt[1:0]][30:0];
                    end
                    if (r_cnt != '0) begin
                        r_sum <= r_sum + WIDE_W'(r_sq);
                    end
                    if (r_cnt == 5'd3) begin
                        r_x     <= r_sum + WIDE_W'(r_sq);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= N_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                N_SQRT: begin
                    if (w_rem >= w_trial) begin
                        r_rem  <= w_rem - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_x <= r_x << 2;
                    if (r_cnt == 5'd31) begin
                        r_state <= N_PREP;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                N_PREP: begin
                    // Numerator is the magnitude in Q30 plus half the norm.
                    for (int i = 0; i < 3; i++) begin
                        r_drem[i] <= {2'b00, w_numer[i][61:31]};
                        r_num[i]  <= w_numer[i][30:0];
                        r_q[i]    <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_dtry[i] >= {1'b0, r_root}) begin
                            r_drem[i] <= w_dtry[i] - {1'b0, r_root};
                            r_q[i]    <= {r_q[i][29:0], 1'b1};
                        end else begin
                            r_drem[i] <= w_dtry[i];
                            r_q[i]    <= {r_q[i][29:0], 1'b0};
                        end
                        r_num[i] <= r_num[i] << 1;
                    end
                    if (r_cnt == 5'd30) begin
                        r_done  <= 1'b1;
                        r_zero  <= 1'b0;
                        r_state <= N_IDLE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lvm_back.sv */
// ----------------------------------------------------------------------------
// lvm_back: basis and matrix row sequencer
// Runs the parallel test and cross products on the shared multiplier, the two
// normalizations in lvm_norm; forms the three rows and queues them for output.
// ----------------------------------------------------------------------------
module lvm_back import lvm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job_req i_req,
    output logic     o_ready,
    input  logic     pop,
    output logic     empty,
    output t_res     o_res
);

    typedef enum logic [7:0] {
        B_IDLE   = 8'b00000001,
        B_PAR    = 8'b00000010,
        B_NORMF  = 8'b00000100,
        B_CROSS1 = 8'b00001000,
        B_NORMS  = 8'b00010000,
        B_CROSS2 = 8'b00100000,
        B_DOT    = 8'b01000000,
        B_EMIT   = 8'b10000000
    } t_bstate;

    localparam int ESH = UNIT_BITS - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF_OFF = PROD_W'(64'd1 << (UNIT_BITS - 1));
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    t_bstate                   r_state;
    t_coord                    r_eye [3];
    t_diff                     r_d [3];
    t_coord                    r_up [3];
    t_unit                     r_f [3];
    t_unit                     r_s [3];
    t_row_v                    r_t [3];
    t_wide                     r_cx [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_hold;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic [1:0]                w_ai;
    logic [1:0]                w_bi;
    logic [1:0]                w_di;
    logic [2:0]                w_k;
    logic [1:0]                w_comp;
    logic                      w_nz_fin;
    logic                      w_upbig;
    t_row_v                    w_rv [3];
    t_wide                     w_nvec [3];
    t_unit                     w_unit [3];
    t_norm_stat                w_nstat;
    logic                      r_nstart;
    logic                      r_nz;
    logic                      r_deg;
    logic [1:0]                r_row;
    logic [2:0]                r_cnt;
    t_res                      w_res;
    t_res                      r_oq [QDEPTH];
    logic [QPTR_W-1:0]         r_owp;
    logic [QPTR_W-1:0]         r_orp;
    logic [QPTR_W:0]           r_ocnt;
    logic                      w_oq_full;
    logic                      w_opush;
    logic                      w_opop;

    // Operand order of a cross product a x b, two products per component.
    function automatic logic [1:0] cross_a(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Q60 to Q30, nearest with ties away from zero.
    function automatic t_row_v round_unit(input t_wide t);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] r;
        m = t[WIDE_W-1] ? WIDE_W'(-t) : WIDE_W'(t);
        r = (m + (WIDE_W'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
        return t[WIDE_W-1] ? -ROW_W'(r) : ROW_W'(r);
    endfunction

    // Q30 to Q16, nearest with ties away from zero; cannot leave the range.
    function automatic t_coord round_entry(input t_row_v v);
        logic [ROW_W-1:0] m;
        logic [ROW_W-1:0] r;
        m = v[ROW_W-1] ? ROW_W'(-v) : ROW_W'(v);
        r = (m + (ROW_W'(1) << (ESH - 1))) >> ESH;
        return v[ROW_W-1] ? -COORD_W'(r) : COORD_W'(r);
    endfunction

    // Negated dot product to Q16, ties toward plus infinity, saturated.
    function automatic t_coord sat_offset(input logic signed [PROD_W-1:0] acc);
        logic signed [PROD_W-1:0] v;
        logic signed [PROD_W-1:0] sh;
        t_coord r;
        v  = HALF_OFF - acc;
        sh = v >>> UNIT_BITS;
        if ((&sh[PROD_W-1:COORD_W-1]) || !(|sh[PROD_W-1:COORD_W-1])) begin
            r = sh[COORD_W-1:0];
        end else if (sh[PROD_W-1]) begin
            r = COORD_MIN;
        end else begin
            r = COORD_MAX;
        end
        return r;
    endfunction

    // Halves a magnitude, keeping the sign, for the up vector prescale.
    function automatic t_coord half_coord(input t_coord v);
        logic signed [COORD_W:0] w;
        logic [COORD_W:0]        m;
        w = {v[COORD_W-1], v};
        m = v[COORD_W-1] ? (COORD_W+1)'(-w) : (COORD_W+1)'(w);
        m = m >> 1;
        return v[COORD_W-1] ? -COORD_W'(m) : COORD_W'(m);
    endfunction

    always_comb begin
        w_ai   = cross_a(r_cnt);
        w_bi   = cross_b(r_cnt);
        w_di   = (r_cnt < 3'd3) ? r_cnt[1:0] : 2'd0;
        w_k    = r_cnt - 3'd1;
        w_comp = w_k[2:1];
        for (int i = 0; i < 3; i++) begin
            unique case (r_row)
                ROW_SIDE: w_rv[i] = ROW_W'(r_s[i]);
                ROW_UP:   w_rv[i] = r_t[i];
                ROW_FWD:  w_rv[i] = -ROW_W'(r_f[i]);
                default:  w_rv[i] = '0;
            endcase
            w_nvec[i] = (r_state == B_NORMF) ? WIDE_W'(r_d[i]) : r_cx[i];
        end
        unique case (r_state)
            B_PAR: begin
                w_ma = MUL_W'(r_d[w_ai]);
                w_mb = MUL_W'(r_up[w_bi]);
            end
            B_CROSS1: begin
                w_ma = MUL_W'(r_f[w_ai]);
                w_mb = MUL_W'(r_up[w_bi]);
            end
            B_CROSS2: begin
                w_ma = MUL_W'(r_s[w_ai]);
                w_mb = MUL_W'(r_f[w_bi]);
            end
            B_DOT: begin
                w_ma = MUL_W'(w_rv[w_di]);
                w_mb = MUL_W'(r_eye[w_di]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod   = w_ma * w_mb;
        w_diff   = r_hold - r_prod;
        w_nz_fin = r_nz || (w_diff != '0);
        w_upbig  = (r_up[0] == COORD_MIN) || (r_up[1] == COORD_MIN)
                || (r_up[2] == COORD_MIN);
    end

    lvm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (w_nvec),
        .o_stat  (w_nstat),
        .o_unit  (w_unit)
    );

    assign o_ready = (r_state == B_IDLE);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_row    <= ROW_SIDE;
            r_nstart <= 1'b0;
            r_deg    <= 1'b0;
            r_nz     <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_req.valid) begin
                        r_eye[0] <= i_req.job.eye_x;
                        r_eye[1] <= i_req.job.eye_y;
                        r_eye[2] <= i_req.job.eye_z;
                        r_d[0]   <= i_req.job.d_x;
                        r_d[1]   <= i_req.job.d_y;
                        r_d[2]   <= i_req.job.d_z;
                        r_up[0]  <= i_req.job.up_x;
                        r_up[1]  <= i_req.job.up_y;
                        r_up[2]  <= i_req.job.up_z;
                        r_deg    <= i_req.job.early_deg;
                        r_nz     <= 1'b0;
                        r_cnt    <= '0;
                        r_row    <= ROW_SIDE;
                        r_state  <= i_req.job.early_deg ? B_EMIT : B_PAR;
                    end
                end
                B_PAR, B_CROSS1, B_CROSS2: begin
                    if (r_cnt != '0) begin
                        if (!w_k[0]) begin
                            r_hold <= r_prod;
                        end else begin
                            r_cx[w_comp] <= $signed(w_diff[WIDE_W-1:0]);
                            r_t[w_comp]  <= round_unit($signed(w_diff[WIDE_W-1:0]));
                            if (w_diff != '0) begin
                                r_nz <= 1'b1;
                            end
                        end
                    end
                    if (r_cnt == 3'd6) begin
                        r_cnt <= '0;
                        priority if (r_state == B_PAR) begin
                            if (!w_nz_fin) begin
                                r_deg   <= 1'b1;
                                r_state <= B_EMIT;
                            end else begin
                                if (w_upbig) begin
                                    for (int i = 0; i < 3; i++) begin
                                        r_up[i] <= half_coord(r_up[i]);
                                    end
                                end
                                r_nstart <= 1'b1;
                                r_state  <= B_NORMF;
                            end
                        end else if (r_state == B_CROSS1) begin
                            r_nstart <= 1'b1;
                            r_state  <= B_NORMS;
                        end else begin
                            r_row   <= ROW_SIDE;
                            r_state <= B_DOT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_NORMF: begin
                    if (w_nstat.done) begin
                        r_f     <= w_unit;
                        r_state <= B_CROSS1;
                    end
                end
                B_NORMS: begin
                    if (w_nstat.done) begin
                        if (w_nstat.zero) begin
                            r_deg   <= 1'b1;
                            r_row   <= ROW_SIDE;
                            r_state <= B_EMIT;
                        end else begin
                            r_s     <= w_unit;
                            r_state <= B_CROSS2;
                        end
                    end
                end
                B_DOT: begin
                    if (r_cnt == '0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_state <= B_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_EMIT: begin
                    if (!w_oq_full) begin
                        if (r_row == ROW_FWD) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_cnt   <= '0;
                            r_state <= r_deg ? B_EMIT : B_DOT;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_comb begin
        w_res.row_index  = r_row;
        w_res.degenerate = r_deg;
        w_res.final_row  = (r_row == ROW_FWD);
        if (r_deg) begin
            w_res.col_x  = '0;
            w_res.col_y  = '0;
            w_res.col_z  = '0;
            w_res.offset = '0;
        end else begin
            w_res.col_x  = round_entry(w_rv[0]);
            w_res.col_y  = round_entry(w_rv[1]);
            w_res.col_z  = round_entry(w_rv[2]);
            w_res.offset = sat_offset(r_acc);
        end
    end

    assign w_oq_full = (r_ocnt == (QPTR_W+1)'(QDEPTH));
    assign w_opush   = (r_state == B_EMIT) && !w_oq_full;
    assign empty     = (r_ocnt == '0);
    assign w_opop    = pop && !empty;
    assign o_res     = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_opush) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_opop) begin
                r_orp <= r_orp + 1'b1;
            end
            unique case ({w_opush, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= w_res;
        end
    end

endmodule

/* hw/rtl/lookat_view_matrix.sv */
// ----------------------------------------------------------------------------
// lookat_view_matrix: fixed-point look-at camera matrix
// Builds the side, true up and negated forward rows of a view matrix, with
// their translation terms, from eye, target and up vectors in Q16.16.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake         Transfer when       Payload
//   input    push / full       push && !full       eye, target, up (x, y, z)
//   result   empty / pop       pop && !empty       row_index, col_x/y/z,
//                                                  offset, degenerate, final_row
//
// Each setup produces three result transfers, rows 0, 1 and 2 in order.
// In the back end of a setup with a basis, the two normalizations dominate,
// each a 32-step square root followed by a 31-step divide, around the cross
// product passes on the shared multiplier. A setup whose eye equals its
// target or whose up vector is zero skips straight to its rows. Reset is
// synchronous and active low and empties both queues.
// The front queue holds two setups and the result queue two rows, so either
// side may stall without stopping the other until its queue fills.
//
module lookat_view_matrix import lvm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  t_coord i_eye_x,
    input  t_coord i_eye_y,
    input  t_coord i_eye_z,
    input  t_coord i_target_x,
    input  t_coord i_target_y,
    input  t_coord i_target_z,
    input  t_coord i_up_x,
    input  t_coord i_up_y,
    input  t_coord i_up_z,
    input  logic   pop,
    output logic   empty,
    output logic [1:0] o_row_index,
    output t_coord o_col_x,
    output t_coord o_col_y,
    output t_coord o_col_z,
    output t_coord o_offset,
    output logic   o_degenerate,
    output logic   o_final_row
);

    t_job_req w_req;
    logic     w_ready;
    t_res     w_res;

    // Front end: forms target minus eye and queues the job.
    lvm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_up_x     (i_up_x),
        .i_up_y     (i_up_y),
        .i_up_z     (i_up_z),
        .o_req      (w_req),
        .i_ready    (w_ready)
    );

    // Back end: basis, rows and the result queue.
    lvm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_ready (w_ready),
        .pop     (pop),
        .empty   (empty),
        .o_res   (w_res)
    );

    // The oldest queued row is always presented on the result ports.
    assign o_row_index  = w_res.row_index;
    assign o_col_x      = w_res.col_x;
    assign o_col_y      = w_res.col_y;
    assign o_col_z      = w_res.col_z;
    assign o_offset     = w_res.offset;
    assign o_degenerate = w_res.degenerate;
    assign o_final_row  = w_res.final_row;

endmodule

/* hw/rtl/lvm_checker.sv */
// ----------------------------------------------------------------------------
// lvm_checker: port-level checks of the look-at block
// Watches the result queue and reset behavior on the top-level ports.
// ----------------------------------------------------------------------------
module lvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_row_index,
    input logic [31:0] o_col_x,
    input logic [31:0] o_col_y,
    input logic [31:0] o_col_z,
    input logic [31:0] o_offset,
    input logic        o_degenerate,
    input logic        o_final_row
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_row_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row_index) && $stable(o_offset)))
        else $error("waiting row changed before its transfer");

    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_final_row == (o_row_index == 2'd2)))
        else $error("final_row disagrees with row_index");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |->
            ((o_col_x == '0) && (o_col_y == '0) && (o_col_z == '0) && (o_offset == '0)))
        else $error("degenerate row carries nonzero entries");

endmodule

bind lookat_view_matrix lvm_checker u_lvm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_row_index  (o_row_index),
    .o_col_x      (o_col_x),
    .o_col_y      (o_col_y),
    .o_col_z      (o_col_z),
    .o_offset     (o_offset),
    .o_degenerate (o_degenerate),
    .o_final_row  (o_final_row)
);
